@@ rtl/pgs_pkg.sv @@
// shared constants and arithmetic helpers for the particle gravity step block
package pgs_pkg;

    // fixed point format of positions and velocities
    localparam int FRAC_BITS = 16;

    // operation codes
    localparam logic [1:0] OP_LOAD  = 2'd0;
    localparam logic [1:0] OP_FRAME = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;

    // configuration register indexes
    localparam logic [2:0] REG_COUNT  = 3'd0;
    localparam logic [2:0] REG_WIDTH  = 3'd1;
    localparam logic [2:0] REG_HEIGHT = 3'd2;
    localparam logic [2:0] REG_CDIST  = 3'd3;
    localparam logic [2:0] REG_GAIN   = 3'd4;
    localparam logic [2:0] REG_LIMIT  = 3'd5;

    // configuration reset values
    localparam logic [8:0]  RST_COUNT  = 9'd256;
    localparam logic [11:0] RST_WIDTH  = 12'd1280;
    localparam logic [11:0] RST_HEIGHT = 12'd640;
    localparam logic [7:0]  RST_CDIST  = 8'd4;
    localparam logic [15:0] RST_GAIN   = 16'd256;
    localparam logic [20:0] RST_LIMIT  = 21'd65536;

    // saturation bounds
    localparam logic signed [21:0] VEL_MAX   = 22'sd1048576;
    localparam logic [28:0]        TOTAL_MAX = 29'd268435456;

    // iteration counts of the shared root and divide units
    localparam logic [5:0] SQ_STEPS  = 6'd25;
    localparam logic [5:0] DIV_STEPS = 6'd49;

    // velocity saturation to +-VEL_MAX
    function automatic logic signed [21:0] sat_vel(input logic signed [51:0] v);
        logic signed [51:0] hi;
        hi = 52'sd1048576;
        if (v > hi) begin
            return VEL_MAX;
        end else if (v < -hi) begin
            return -VEL_MAX;
        end
        return v[21:0];
    endfunction

    // position saturation to the signed 32 bit range
    function automatic logic signed [31:0] sat_pos(input logic signed [32:0] v);
        if (v[32] != v[31]) begin
            return v[32] ? 32'sh8000_0000 : 32'sh7fff_ffff;
        end
        return v[31:0];
    endfunction

    // wall reflection of one velocity component
    function automatic logic signed [21:0] wall_vel(input logic signed [31:0] pos,
                                                    input logic signed [21:0] vel,
                                                    input logic [11:0] size);
        logic signed [32:0] nxt;
        logic [32:0]        mag;
        logic signed [18:0] whole;
        logic signed [18:0] hi;
        nxt   = $signed({pos[31], pos}) + $signed({{11{vel[21]}}, vel});
        mag   = nxt[32] ? 33'(-nxt) : 33'(nxt);
        whole = nxt[32] ? -$signed({2'b00, mag[32:FRAC_BITS]})
                        : $signed({2'b00, mag[32:FRAC_BITS]});
        hi    = $signed({7'd0, size}) - 19'sd2;
        if (whole > hi || whole < 19'sd1) begin
            return -vel;
        end
        return vel;
    endfunction

endpackage

@@ rtl/particle_gravity_step_top.sv @@
// particle table with direct pairwise gravity, speed clamp and wall bounce
//
//  channel  | handshake                    | word
//  ---------+------------------------------+-----------------------------------
//  command  | start, busy                  | operation, index, load position/vel
//  result   | o_done (one cycle strobe)    | status, read position/vel, speed total
//  config   | psel, penable, pwrite, pready| paddr, pwdata, prdata
//
// a frame walks every pair, where a repelling pair skips the root unit, then every particle
// once; its length is set by the one-bit-a-cycle root (25 steps) and divide (49 steps)
// units and the single port of each table memory.
// reset is synchronous and clears control and configuration only; table entries
// hold nothing until loaded. results cannot be stalled; busy stays high until
// the result strobe cycle, in which a new command may already be taken.
module particle_gravity_step_top #(
    parameter int MAX_PARTICLES = 256
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_operation,
    input  logic [7:0]         i_particle_index,
    input  logic [27:0]        i_load_pos_x,
    input  logic [27:0]        i_load_pos_y,
    input  logic signed [21:0] i_load_vel_x,
    input  logic signed [21:0] i_load_vel_y,
    output logic               o_done,
    output logic               o_status,
    output logic signed [31:0] o_read_pos_x,
    output logic signed [31:0] o_read_pos_y,
    output logic signed [21:0] o_read_vel_x,
    output logic signed [21:0] o_read_vel_y,
    output logic [28:0]        o_speed_total,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [4:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int AW = (MAX_PARTICLES > 1) ? $clog2(MAX_PARTICLES) : 1;
    localparam int CW = $clog2(MAX_PARTICLES + 1);

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_CMD    = 5'd1;
    localparam logic [4:0] S_RD     = 5'd2;
    localparam logic [4:0] S_PI_RD  = 5'd3;
    localparam logic [4:0] S_PI_LAT = 5'd4;
    localparam logic [4:0] S_PJ     = 5'd5;
    localparam logic [4:0] S_MUL    = 5'd6;
    localparam logic [4:0] S_CMP    = 5'd7;
    localparam logic [4:0] S_SQ     = 5'd8;
    localparam logic [4:0] S_M1     = 5'd9;
    localparam logic [4:0] S_M2     = 5'd10;
    localparam logic [4:0] S_DIV    = 5'd11;
    localparam logic [4:0] S_APPLY  = 5'd12;
    localparam logic [4:0] S_NEXTJ  = 5'd13;
    localparam logic [4:0] S_WI     = 5'd14;
    localparam logic [4:0] S_SP_RD  = 5'd15;
    localparam logic [4:0] S_SP_LAT = 5'd16;
    localparam logic [4:0] S_SP_CHK = 5'd17;
    localparam logic [4:0] S_SP_SET = 5'd18;
    localparam logic [4:0] S_WALL   = 5'd19;
    localparam logic [4:0] S_MOVE   = 5'd20;

    logic [4:0] r_state;

    // configuration registers
    logic [8:0]  r_count;
    logic [11:0] r_width;
    logic [11:0] r_height;
    logic [7:0]  r_cdist;
    logic [15:0] r_gain;
    logic [20:0] r_limit;

    // latched command word
    logic [1:0]         r_op;
    logic [7:0]         r_idx;
    logic [27:0]        r_ld_px;
    logic [27:0]        r_ld_py;
    logic signed [21:0] r_ld_vx;
    logic signed [21:0] r_ld_vy;

    // loop counters and working values
    logic [CW-1:0]      r_i;
    logic [CW-1:0]      r_j;
    logic signed [31:0] r_pix;
    logic signed [31:0] r_piy;
    logic signed [21:0] r_vix;
    logic signed [21:0] r_viy;
    logic signed [21:0] r_vjx;
    logic signed [21:0] r_vjy;
    logic signed [32:0] r_dx;
    logic signed [32:0] r_dy;
    logic               r_dxneg;
    logic               r_dyneg;
    logic               r_repel;
    logic [48:0]        r_gdx;
    logic [48:0]        r_gdy;
    logic [33:0]        r_d2;
    logic [41:0]        r_p0;
    logic [41:0]        r_p1;
    logic               r_phase;
    logic [5:0]         r_cnt;
    logic [20:0]        r_s;
    logic [28:0]        r_total;

    // root unit
    logic [49:0] r_sq_rad;
    logic [26:0] r_sq_rem;
    logic [24:0] r_sq_root;

    // dual divide unit sharing one divisor
    logic [59:0] r_den;
    logic [48:0] r_qx;
    logic [48:0] r_qy;
    logic [59:0] r_rx;
    logic [59:0] r_ry;

    // result registers
    logic               r_done;
    logic               r_status;
    logic signed [31:0] r_out_px;
    logic signed [31:0] r_out_py;
    logic signed [21:0] r_out_vx;
    logic signed [21:0] r_out_vy;
    logic [28:0]        r_out_total;

    // table memories
    logic [63:0] r_pos_mem [MAX_PARTICLES];
    logic [43:0] r_vel_mem [MAX_PARTICLES];
    logic [63:0] r_pos_rd;
    logic [43:0] r_vel_rd;

    logic [CW-1:0]      mem_idx;
    logic [AW-1:0]      mem_addr;
    logic               pos_we;
    logic               vel_we;
    logic [63:0]        pos_wd;
    logic [43:0]        vel_wd;

    logic               accept;
    logic               cfg_wr;
    logic [CW-1:0]      n_eff;
    logic               idx_bad;
    logic [CW-1:0]      i_plus1;
    logic [CW-1:0]      j_plus1;
    logic [CW-1:0]      idx_w;

    // combinational arithmetic
    logic [32:0]        adx;
    logic [32:0]        ady;
    logic [16:0]        aix;
    logic [16:0]        aiy;
    logic [15:0]        c2;
    logic [60:0]        dsh_x;
    logic [60:0]        dsh_y;
    logic [28:0]        sq_sh;
    logic [28:0]        sq_trial;
    logic signed [49:0] ax;
    logic signed [49:0] ay;
    logic signed [21:0] vix_new;
    logic signed [21:0] viy_new;
    logic signed [21:0] vjx_new;
    logic signed [21:0] vjy_new;
    logic signed [21:0] rd_vx;
    logic signed [21:0] rd_vy;
    logic [20:0]        avx;
    logic [20:0]        avy;
    logic [20:0]        avx_rd;
    logic [20:0]        avy_rd;
    logic [29:0]        total_sum;
    logic signed [31:0] pos_x_new;
    logic signed [31:0] pos_y_new;

    assign accept  = start && !busy;
    assign busy    = (r_state != S_IDLE);
    assign cfg_wr  = psel && penable && pwrite && pready;
    assign pready  = 1'b1;

    assign n_eff   = ({23'd0, r_count} > 32'(MAX_PARTICLES)) ? CW'(MAX_PARTICLES)
                                                              : CW'(r_count);
    assign idx_bad = ({24'd0, r_idx} >= 32'(n_eff));
    assign i_plus1 = r_i + CW'(1);
    assign j_plus1 = r_j + CW'(1);
    assign idx_w   = CW'(r_idx);

    // pair geometry
    assign adx = r_dx[32] ? 33'(-r_dx) : 33'(r_dx);
    assign ady = r_dy[32] ? 33'(-r_dy) : 33'(r_dy);
    assign aix = adx[32:pgs_pkg::FRAC_BITS];
    assign aiy = ady[32:pgs_pkg::FRAC_BITS];
    assign c2  = r_cdist * r_cdist;

    // root and divide step values
    assign sq_sh    = {r_sq_rem, r_sq_rad[49:48]};
    assign sq_trial = {2'b00, r_sq_root, 2'b01};
    assign dsh_x    = {r_rx, r_qx[48]};
    assign dsh_y    = {r_ry, r_qy[48]};

    // signed pair acceleration and velocity updates
    assign ax = (r_dxneg ^ r_repel) ? -$signed({1'b0, r_qx}) : $signed({1'b0, r_qx});
    assign ay = (r_dyneg ^ r_repel) ? -$signed({1'b0, r_qy}) : $signed({1'b0, r_qy});
    assign vix_new = pgs_pkg::sat_vel($signed({{30{r_vix[21]}}, r_vix})
                                      + $signed({{2{ax[49]}}, ax}));
    assign viy_new = pgs_pkg::sat_vel($signed({{30{r_viy[21]}}, r_viy})
                                      + $signed({{2{ay[49]}}, ay}));
    assign vjx_new = pgs_pkg::sat_vel($signed({{30{r_vjx[21]}}, r_vjx})
                                      - $signed({{2{ax[49]}}, ax}));
    assign vjy_new = pgs_pkg::sat_vel($signed({{30{r_vjy[21]}}, r_vjy})
                                      - $signed({{2{ay[49]}}, ay}));

    // speed magnitudes
    assign rd_vx  = r_vel_rd[43:22];
    assign rd_vy  = r_vel_rd[21:0];
    assign avx_rd = rd_vx[21] ? 21'(-rd_vx) : 21'(rd_vx);
    assign avy_rd = rd_vy[21] ? 21'(-rd_vy) : 21'(rd_vy);
    assign avx    = r_vix[21] ? 21'(-r_vix) : 21'(r_vix);
    assign avy    = r_viy[21] ? 21'(-r_viy) : 21'(r_viy);

    assign total_sum = 30'(r_total) + 30'(r_s);
    assign pos_x_new = pgs_pkg::sat_pos($signed({r_pix[31], r_pix})
                                        + $signed({{11{r_vix[21]}}, r_vix}));
    assign pos_y_new = pgs_pkg::sat_pos($signed({r_piy[31], r_piy})
                                        + $signed({{11{r_viy[21]}}, r_viy}));

    // memory address and write selection
    always_comb begin
        mem_idx = r_i;
        pos_we  = 1'b0;
        vel_we  = 1'b0;
        pos_wd  = {r_pix, r_piy};
        vel_wd  = {r_vix, r_viy};
        unique case (r_state)
            S_CMD: begin
                mem_idx = idx_w;
                if (r_op == pgs_pkg::OP_LOAD && !idx_bad) begin
                    pos_we = 1'b1;
                    vel_we = 1'b1;
                    pos_wd = {4'd0, r_ld_px, 4'd0, r_ld_py};
                    vel_wd = {pgs_pkg::sat_vel({{30{r_ld_vx[21]}}, r_ld_vx}),
                              pgs_pkg::sat_vel({{30{r_ld_vy[21]}}, r_ld_vy})};
                end
            end
            S_PI_LAT: mem_idx = i_plus1;
            S_NEXTJ:  mem_idx = j_plus1;
            S_APPLY: begin
                mem_idx = r_j;
                vel_we  = 1'b1;
                vel_wd  = {vjx_new, vjy_new};
            end
            S_WI: vel_we = 1'b1;
            S_MOVE: begin
                pos_we = 1'b1;
                vel_we = 1'b1;
                pos_wd = {pos_x_new, pos_y_new};
            end
            default: mem_idx = r_i;
        endcase
    end

    assign mem_addr = mem_idx[AW-1:0];

    // table memories, one port each, registered read
    always_ff @(posedge i_clk) begin
        if (pos_we) begin
            r_pos_mem[mem_addr] <= pos_wd;
        end
        r_pos_rd <= r_pos_mem[mem_addr];
    end

    always_ff @(posedge i_clk) begin
        if (vel_we) begin
            r_vel_mem[mem_addr] <= vel_wd;
        end
        r_vel_rd <= r_vel_mem[mem_addr];
    end

    // configuration read
    always_comb begin
        unique case (paddr[4:2])
            pgs_pkg::REG_COUNT:  prdata = {23'd0, r_count};
            pgs_pkg::REG_WIDTH:  prdata = {20'd0, r_width};
            pgs_pkg::REG_HEIGHT: prdata = {20'd0, r_height};
            pgs_pkg::REG_CDIST:  prdata = {24'd0, r_cdist};
            pgs_pkg::REG_GAIN:   prdata = {16'd0, r_gain};
            pgs_pkg::REG_LIMIT:  prdata = {11'd0, r_limit};
            default:             prdata = 32'd0;
        endcase
    end

    // configuration write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= pgs_pkg::RST_COUNT;
            r_width  <= pgs_pkg::RST_WIDTH;
            r_height <= pgs_pkg::RST_HEIGHT;
            r_cdist  <= pgs_pkg::RST_CDIST;
            r_gain   <= pgs_pkg::RST_GAIN;
            r_limit  <= pgs_pkg::RST_LIMIT;
        end else if (cfg_wr) begin
            unique case (paddr[4:2])
                pgs_pkg::REG_COUNT:  r_count  <= pwdata[8:0];
                pgs_pkg::REG_WIDTH:  r_width  <= pwdata[11:0];
                pgs_pkg::REG_HEIGHT: r_height <= pwdata[11:0];
                pgs_pkg::REG_CDIST:  r_cdist  <= pwdata[7:0];
                pgs_pkg::REG_GAIN:   r_gain   <= pwdata[15:0];
                pgs_pkg::REG_LIMIT:  r_limit  <= pwdata[20:0];
                default: ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done  <= 1'b0;
        end else begin
            r_done <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_op    <= i_operation;
                        r_idx   <= i_particle_index;
                        r_ld_px <= i_load_pos_x;
                        r_ld_py <= i_load_pos_y;
                        r_ld_vx <= i_load_vel_x;
                        r_ld_vy <= i_load_vel_y;
                        r_state <= S_CMD;
                    end
                end
                S_CMD: begin
                    r_status    <= 1'b0;
                    r_out_px    <= '0;
                    r_out_py    <= '0;
                    r_out_vx    <= '0;
                    r_out_vy    <= '0;
                    r_out_total <= '0;
                    r_i         <= '0;
                    r_total     <= '0;
                    unique case (r_op)
                        pgs_pkg::OP_LOAD: begin
                            r_status <= idx_bad;
                            r_done   <= 1'b1;
                            r_state  <= S_IDLE;
                        end
                        pgs_pkg::OP_READ: begin
                            if (idx_bad) begin
                                r_status <= 1'b1;
                                r_done   <= 1'b1;
                                r_state  <= S_IDLE;
                            end else begin
                                r_state <= S_RD;
                            end
                        end
                        pgs_pkg::OP_FRAME: begin
                            if (n_eff >= CW'(2)) begin
                                r_state <= S_PI_RD;
                            end else if (n_eff != '0) begin
                                r_state <= S_SP_RD;
                            end else begin
                                r_done  <= 1'b1;
                                r_state <= S_IDLE;
                            end
                        end
                        default: begin
                            r_done  <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    endcase
                end
                S_RD: begin
                    r_out_px <= r_pos_rd[63:32];
                    r_out_py <= r_pos_rd[31:0];
                    r_out_vx <= r_vel_rd[43:22];
                    r_out_vy <= r_vel_rd[21:0];
                    r_done   <= 1'b1;
                    r_state  <= S_IDLE;
                end
                // pair walk: row particle held in registers
                S_PI_RD: r_state <= S_PI_LAT;
                S_PI_LAT: begin
                    r_pix   <= r_pos_rd[63:32];
                    r_piy   <= r_pos_rd[31:0];
                    r_vix   <= r_vel_rd[43:22];
                    r_viy   <= r_vel_rd[21:0];
                    r_j     <= i_plus1;
                    r_state <= S_PJ;
                end
                S_PJ: begin
                    r_dx    <= $signed({r_pos_rd[63], r_pos_rd[63:32]})
                               - $signed({r_pix[31], r_pix});
                    r_dy    <= $signed({r_pos_rd[31], r_pos_rd[31:0]})
                               - $signed({r_piy[31], r_piy});
                    r_vjx   <= r_vel_rd[43:22];
                    r_vjy   <= r_vel_rd[21:0];
                    r_state <= S_MUL;
                end
                S_MUL: begin
                    r_d2    <= 34'(aix * aix) + 34'(aiy * aiy);
                    r_gdx   <= adx * r_gain;
                    r_gdy   <= ady * r_gain;
                    r_dxneg <= r_dx[32];
                    r_dyneg <= r_dy[32];
                    r_state <= S_CMP;
                end
                S_CMP: begin
                    r_phase <= 1'b0;
                    r_cnt   <= '0;
                    r_qx    <= r_gdx;
                    r_qy    <= r_gdy;
                    r_rx    <= '0;
                    r_ry    <= '0;
                    if (r_d2 > {18'd0, c2}) begin
                        // attraction needs the root of d2 in Q8
                        r_repel   <= 1'b0;
                        r_sq_rad  <= {r_d2, 16'd0};
                        r_sq_rem  <= '0;
                        r_sq_root <= '0;
                        r_state   <= S_SQ;
                    end else if (r_d2 != '0) begin
                        r_repel <= 1'b1;
                        r_den   <= {18'd0, r_d2, 8'd0};
                        r_state <= S_DIV;
                    end else begin
                        r_state <= S_NEXTJ;
                    end
                end
                // root unit, two radicand bits a cycle
                S_SQ: begin
                    if (sq_sh >= sq_trial) begin
                        r_sq_rem  <= 27'(sq_sh - sq_trial);
                        r_sq_root <= {r_sq_root[23:0], 1'b1};
                    end else begin
                        r_sq_rem  <= sq_sh[26:0];
                        r_sq_root <= {r_sq_root[23:0], 1'b0};
                    end
                    r_sq_rad <= {r_sq_rad[47:0], 2'b00};
                    r_cnt    <= r_cnt + 6'd1;
                    if (r_cnt == pgs_pkg::SQ_STEPS - 6'd1) begin
                        r_cnt   <= '0;
                        r_state <= r_phase ? S_SP_CHK : S_M1;
                    end
                end
                // divisor d2 * q as two partial products
                S_M1: begin
                    r_p0    <= r_d2[16:0] * r_sq_root;
                    r_p1    <= r_d2[33:17] * r_sq_root;
                    r_state <= S_M2;
                end
                S_M2: begin
                    r_den   <= 60'(r_p0) + (60'(r_p1) << 17);
                    r_state <= S_DIV;
                end
                // divide unit, one quotient bit a cycle on both axes
                S_DIV: begin
                    if (dsh_x >= {1'b0, r_den}) begin
                        r_rx <= 60'(dsh_x - {1'b0, r_den});
                        r_qx <= {r_qx[47:0], 1'b1};
                    end else begin
                        r_rx <= dsh_x[59:0];
                        r_qx <= {r_qx[47:0], 1'b0};
                    end
                    if (dsh_y >= {1'b0, r_den}) begin
                        r_ry <= 60'(dsh_y - {1'b0, r_den});
                        r_qy <= {r_qy[47:0], 1'b1};
                    end else begin
                        r_ry <= dsh_y[59:0];
                        r_qy <= {r_qy[47:0], 1'b0};
                    end
                    r_cnt <= r_cnt + 6'd1;
                    if (r_cnt == pgs_pkg::DIV_STEPS - 6'd1) begin
                        r_cnt   <= '0;
                        r_state <= r_phase ? S_SP_SET : S_APPLY;
                    end
                end
                // i accumulates in registers, j is written back now
                S_APPLY: begin
                    r_vix   <= vix_new;
                    r_viy   <= viy_new;
                    r_state <= S_NEXTJ;
                end
                S_NEXTJ: begin
                    r_j     <= j_plus1;
                    r_state <= (j_plus1 < n_eff) ? S_PJ : S_WI;
                end
                S_WI: begin
                    if (i_plus1 + CW'(1) < n_eff) begin
                        r_i     <= i_plus1;
                        r_state <= S_PI_RD;
                    end else begin
                        r_i     <= '0;
                        r_state <= S_SP_RD;
                    end
                end
                // per particle pass: clamp, total, walls, move
                S_SP_RD: r_state <= S_SP_LAT;
                S_SP_LAT: begin
                    r_pix     <= r_pos_rd[63:32];
                    r_piy     <= r_pos_rd[31:0];
                    r_vix     <= rd_vx;
                    r_viy     <= rd_vy;
                    r_sq_rad  <= 50'(avx_rd * avx_rd) + 50'(avy_rd * avy_rd);
                    r_sq_rem  <= '0;
                    r_sq_root <= '0;
                    r_cnt     <= '0;
                    r_phase   <= 1'b1;
                    r_state   <= S_SQ;
                end
                S_SP_CHK: begin
                    if (r_sq_root > {4'd0, r_limit}) begin
                        r_s     <= r_limit;
                        r_qx    <= 49'(avx * r_limit);
                        r_qy    <= 49'(avy * r_limit);
                        r_rx    <= '0;
                        r_ry    <= '0;
                        r_den   <= 60'(r_sq_root);
                        r_dxneg <= r_vix[21];
                        r_dyneg <= r_viy[21];
                        r_cnt   <= '0;
                        r_state <= S_DIV;
                    end else begin
                        r_s     <= r_sq_root[20:0];
                        r_state <= S_WALL;
                    end
                end
                S_SP_SET: begin
                    r_vix   <= r_dxneg ? -$signed(r_qx[21:0]) : $signed(r_qx[21:0]);
                    r_viy   <= r_dyneg ? -$signed(r_qy[21:0]) : $signed(r_qy[21:0]);
                    r_state <= S_WALL;
                end
                S_WALL: begin
                    r_total <= (total_sum > {1'b0, pgs_pkg::TOTAL_MAX})
                               ? pgs_pkg::TOTAL_MAX : total_sum[28:0];
                    r_vix   <= pgs_pkg::wall_vel(r_pix, r_vix, r_width);
                    r_viy   <= pgs_pkg::wall_vel(r_piy, r_viy, r_height);
                    r_state <= S_MOVE;
                end
                S_MOVE: begin
                    r_i <= i_plus1;
                    if (i_plus1 < n_eff) begin
                        r_state <= S_SP_RD;
                    end else begin
                        r_out_total <= r_total;
                        r_done      <= 1'b1;
                        r_state     <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // result ports
    assign o_done        = r_done;
    assign o_status      = r_status;
    assign o_read_pos_x  = r_out_px;
    assign o_read_pos_y  = r_out_py;
    assign o_read_vel_x  = r_out_vx;
    assign o_read_vel_y  = r_out_vy;
    assign o_speed_total = r_out_total;

endmodule
